@@ hw/rtl/lidar_scan_heading_select_assert.svh @@
// Assertion macros for the lidar scan heading selector.
// Expects clk and rst in the scope of each use.
`ifndef LIDAR_SCAN_HEADING_SELECT_ASSERT_SVH
`define LIDAR_SCAN_HEADING_SELECT_ASSERT_SVH

// same-cycle implication
`define LSH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsh assertion failed");

// next-cycle implication
`define LSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsh assertion failed");

`endif

@@ hw/rtl/lsh_pkg.sv @@
// Package for the lidar scan heading selector.
// Payload types, config register map, verdict codes and angle constants.
package lsh_pkg;

  localparam int RANGE_BITS       = 16;
  localparam int MAX_READINGS_DEF = 1024;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_READINGS_USED = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_START   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_STEP    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FAR_LIMIT     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR_LIMIT    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALID_FLOOR   = 3'd5;

  localparam logic [1:0] VERDICT_EMPTY    = 2'd0;
  localparam logic [1:0] VERDICT_OBSTACLE = 2'd1;
  localparam logic [1:0] VERDICT_GAP      = 2'd2;
  localparam logic [1:0] VERDICT_FARTHEST = 2'd3;

  // pi and pi/12 in units of 2^-12 rad
  localparam logic [14:0] HALF_TURN    = 15'd12868;
  localparam logic [14:0] TWELFTH_TURN = 15'd1072;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range_mm;
    logic                  scan_end;
  } reading_t;

  typedef struct packed {
    logic               alarm;
    logic [1:0]         verdict;
    logic [9:0]         chosen_index;
    logic signed [15:0] heading;
  } result_t;

  typedef struct packed {
    logic [10:0]        readings_used;
    logic signed [15:0] angle_start;
    logic [9:0]         angle_step;
    logic [15:0]        far_limit;
    logic [15:0]        near_limit;
    logic [15:0]        valid_floor;
  } cfg_t;

endpackage

@@ hw/rtl/lsh_cfg.sv @@
// Configuration register file of the lidar scan heading selector.
// Uses lsh_pkg for the register map and cfg_t.
module lsh_cfg import lsh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.readings_used <= 11'd1024;
      cfg.angle_start   <= -16'sd12868;
      cfg.angle_step    <= 10'd26;
      cfg.far_limit     <= 16'd29000;
      cfg.near_limit    <= 16'd2000;
      cfg.valid_floor   <= 16'd150;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_READINGS_USED: cfg.readings_used <= cfg_data[10:0];
        REG_ANGLE_START:   cfg.angle_start   <= $signed(cfg_data);
        REG_ANGLE_STEP:    cfg.angle_step    <= cfg_data[9:0];
        REG_FAR_LIMIT:     cfg.far_limit     <= cfg_data;
        REG_NEAR_LIMIT:    cfg.near_limit    <= cfg_data;
        REG_VALID_FLOOR:   cfg.valid_floor   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/lsh_scan_acc.sv @@
// Per-reading scan accumulator and verdict register.
// Uses lsh_pkg; feeds the verdict code and source index to lsh_heading.
module lsh_scan_acc import lsh_pkg::*; #(
  parameter int MAX_READINGS = MAX_READINGS_DEF,
  localparam int IW = $clog2(MAX_READINGS),
  localparam int PW = $clog2(MAX_READINGS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          beat_valid,
  input  reading_t      beat,
  input  logic          hd_ready,
  output logic          take,
  output logic          vd_valid,
  output logic [1:0]    vd_code,
  output logic [IW-1:0] vd_index
);

  localparam int CW = PW > 11 ? PW : 11;
  localparam int LW = RANGE_BITS > 16 ? RANGE_BITS : 16;

  logic [PW-1:0] position, position_next;
  logic          seen_valid, seen_valid_next;
  logic          near_found, near_found_next;
  logic [IW-1:0] near_index, near_index_next;
  logic [RANGE_BITS-1:0] near_range, near_range_next;
  logic [IW-1:0] farthest_index, farthest_index_next;
  logic [RANGE_BITS-1:0] farthest_range, farthest_range_next;
  logic          gap_seen, gap_seen_next;
  logic [IW-1:0] run_start, run_start_next;
  logic [PW-1:0] run_length, run_length_next;
  logic [PW-1:0] best_length, best_length_next;
  logic [IW-1:0] best_centre, best_centre_next;

  logic          active, in_win, is_near, is_far, ext, close_better, slot_free;
  logic [IW-1:0] idx, cand_start, closed_centre;
  logic [PW-1:0] cand_len, closed_len;
  logic [LW-1:0] r, floor_l, near_l, far_l;
  logic [1:0]    code_next;
  logic [IW-1:0] index_next;

  assign slot_free = !vd_valid || hd_ready;
  assign take      = beat_valid && (!beat.scan_end || slot_free);

  always_comb begin
    r       = LW'(beat.range_mm);
    floor_l = LW'(cfg.valid_floor);
    near_l  = LW'(cfg.near_limit);
    far_l   = LW'(cfg.far_limit);
    active  = (CW'(position) < CW'(cfg.readings_used)) &&
              (CW'(position) < CW'(MAX_READINGS));
    idx     = position[IW-1:0];
    in_win  = (r >= floor_l) && (r <= far_l);
    is_near = (r >= floor_l) && (r <= near_l);
    is_far  = r >= far_l;
    ext     = active && is_far;

    // the far run as it stands after this reading, closed against the best one
    cand_start = ext ? ((run_length == '0) ? idx : run_start) : run_start;
    cand_len   = ext ? PW'(run_length + 1'b1) : run_length;
    close_better  = cand_len > best_length;
    closed_len    = close_better ? cand_len : best_length;
    closed_centre = close_better ? IW'(PW'(cand_start) + (cand_len >> 1)) : best_centre;

    seen_valid_next = seen_valid || (active && in_win);
    near_found_next = near_found;
    near_index_next = near_index;
    near_range_next = near_range;
    if (active && is_near && (!near_found || beat.range_mm < near_range)) begin
      near_found_next = 1'b1;
      near_index_next = idx;
      near_range_next = beat.range_mm;
    end
    farthest_index_next = farthest_index;
    farthest_range_next = farthest_range;
    if (active && (position == '0 || beat.range_mm > farthest_range)) begin
      farthest_index_next = idx;
      farthest_range_next = beat.range_mm;
    end
    gap_seen_next    = gap_seen || ext;
    run_start_next   = ext ? cand_start : run_start;
    run_length_next  = active ? (is_far ? cand_len : '0) : run_length;
    best_length_next = (active && !is_far) ? closed_len : best_length;
    best_centre_next = (active && !is_far) ? closed_centre : best_centre;
    position_next    = active ? PW'(position + 1'b1) : position;

    if (!seen_valid_next) begin
      code_next  = VERDICT_EMPTY;
      index_next = '0;
    end else if (near_found_next) begin
      code_next  = VERDICT_OBSTACLE;
      index_next = near_index_next;
    end else if (gap_seen_next) begin
      code_next  = VERDICT_GAP;
      index_next = closed_centre;
    end else begin
      code_next  = VERDICT_FARTHEST;
      index_next = farthest_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && beat.scan_end)) begin
      position       <= '0;
      seen_valid     <= 1'b0;
      near_found     <= 1'b0;
      near_index     <= '0;
      near_range     <= '0;
      farthest_index <= '0;
      farthest_range <= '0;
      gap_seen       <= 1'b0;
      run_start      <= '0;
      run_length     <= '0;
      best_length    <= '0;
      best_centre    <= '0;
    end else if (take) begin
      position       <= position_next;
      seen_valid     <= seen_valid_next;
      near_found     <= near_found_next;
      near_index     <= near_index_next;
      near_range     <= near_range_next;
      farthest_index <= farthest_index_next;
      farthest_range <= farthest_range_next;
      gap_seen       <= gap_seen_next;
      run_start      <= run_start_next;
      run_length     <= run_length_next;
      best_length    <= best_length_next;
      best_centre    <= best_centre_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd_valid <= 1'b0;
    end else if (slot_free) begin
      vd_valid <= take && beat.scan_end;
    end
  end

  always_ff @(posedge clk) begin
    if (take && beat.scan_end) begin
      vd_code  <= code_next;
      vd_index <= index_next;
    end
  end

endmodule

@@ hw/rtl/lsh_heading.sv @@
// Heading unit: angle of the chosen reading plus offset, saturated, into the
// output register. Uses lsh_pkg for verdict codes, angle constants, result_t.
module lsh_heading import lsh_pkg::*; #(
  parameter int MAX_READINGS = MAX_READINGS_DEF,
  localparam int IW = $clog2(MAX_READINGS)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          vd_valid,
  input  logic [1:0]    vd_code,
  input  logic [IW-1:0] vd_index,
  output logic          hd_ready,
  output logic          verdict_valid,
  input  logic          verdict_stall,
  output result_t       result
);

  localparam int PRW = IW + 10;
  localparam int SW  = (PRW > 16 ? PRW : 16) + 2;
  localparam logic signed [SW-1:0] HMAX = SW'(32767);
  localparam logic signed [SW-1:0] HMIN = SW'(-32768);

  logic [PRW-1:0]       prod;
  logic [14:0]          offset;
  logic signed [SW-1:0] sum;
  logic signed [15:0]   sat;
  logic [IW+9:0]        index_ext;
  result_t              result_next;

  assign hd_ready = !verdict_valid || !verdict_stall;

  always_comb begin
    prod = {{10{1'b0}}, vd_index} * {{IW{1'b0}}, cfg.angle_step};
    case (vd_code)
      VERDICT_OBSTACLE: offset = HALF_TURN;
      VERDICT_FARTHEST: offset = TWELFTH_TURN;
      default:          offset = '0;
    endcase
    sum = $signed({{(SW-16){cfg.angle_start[15]}}, cfg.angle_start})
        + $signed({{(SW-PRW){1'b0}}, prod})
        + $signed({{(SW-15){1'b0}}, offset});
    if (sum > HMAX) begin
      sat = 16'sh7fff;
    end else if (sum < HMIN) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
    index_ext = {10'b0, vd_index};

    result_next.alarm        = vd_code == VERDICT_OBSTACLE;
    result_next.verdict      = vd_code;
    result_next.chosen_index = index_ext[9:0];
    result_next.heading      = (vd_code == VERDICT_EMPTY) ? 16'sd0 : sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (hd_ready) begin
      verdict_valid <= vd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vd_valid && hd_ready) begin
      result <= result_next;
    end
  end

endmodule

@@ hw/rtl/lidar_scan_heading_select.sv @@
// Top level of the lidar scan heading selector; uses lsh_pkg, lsh_cfg,
// lsh_scan_acc, lsh_heading and lidar_scan_heading_select_assert.svh.
//
// Takes one range reading per clock while reading_stall is low. Each reading updates a set of running
// registers in a single pass (closest near hit, farthest reading, current and
// longest far run), so there is no scan memory and no clearing after reset.
// The beat marked scan_end produces one result once it is accepted, passing
// through the input register, the verdict register, then the heading unit (one
// index times step multiply, add, saturate) into the output register. A
// stalled output backs up through these three registers before reading_stall
// rises; readings that do not end a scan keep flowing while the result waits.
module lidar_scan_heading_select import lsh_pkg::*; #(
  parameter int MAX_READINGS = MAX_READINGS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      reading_valid,
  output logic                      reading_stall,
  input  reading_t                  reading,
  output logic                      verdict_valid,
  input  logic                      verdict_stall,
  output result_t                   result
);

  localparam int IW = $clog2(MAX_READINGS);

  `include "lidar_scan_heading_select_assert.svh"

  cfg_t          cfg;
  logic          beat_valid;
  reading_t      beat;
  logic          take;
  logic          hd_ready;
  logic          vd_valid;
  logic [1:0]    vd_code;
  logic [IW-1:0] vd_index;

  assign reading_stall = beat_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!reading_stall) begin
      beat_valid <= reading_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (reading_valid && !reading_stall) begin
      beat <= reading;
    end
  end

  lsh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsh_scan_acc #(.MAX_READINGS(MAX_READINGS)) u_acc (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .beat_valid (beat_valid),
    .beat       (beat),
    .hd_ready   (hd_ready),
    .take       (take),
    .vd_valid   (vd_valid),
    .vd_code    (vd_code),
    .vd_index   (vd_index)
  );

  lsh_heading #(.MAX_READINGS(MAX_READINGS)) u_heading (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .vd_valid      (vd_valid),
    .vd_code       (vd_code),
    .vd_index      (vd_index),
    .hd_ready      (hd_ready),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .result        (result)
  );

  // input only backs up behind a scan end with the verdict slot full
  `LSH_ASSERT_NOW(a_stall_cause, reading_stall, beat_valid && beat.scan_end && vd_valid)
  // a taken scan end always lands in the verdict register
  `LSH_ASSERT_NEXT(a_end_to_verdict, take && beat.scan_end, vd_valid)
  // empty verdict carries index and heading of zero, alarm only on obstacle
  `LSH_ASSERT_NOW(a_result_shape, verdict_valid,
    (result.alarm == (result.verdict == VERDICT_OBSTACLE)) &&
    (result.verdict != VERDICT_EMPTY ||
     (result.heading == 16'sd0 && result.chosen_index == 10'd0)))

endmodule
